// ===== hdl/pwsp_pkg.sv =====
// Package for the PCM WAV stream parser: item and result types, header tags,
// format limits and result codes. No dependencies.
package pwsp_pkg;

  // Extra format bytes allowed after the 16-byte PCM format body.
  localparam int MAX_FMT_EXTRA = 4;
  localparam int EXTRA_W       = $clog2(MAX_FMT_EXTRA + 2);

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_MIN    = 32'd16;
  localparam logic [31:0] FMT_SIZE_MAX    = FMT_SIZE_MIN + 32'(MAX_FMT_EXTRA);
  localparam logic [15:0] FMT_TAG_PCM     = 16'd1;
  localparam logic [15:0] CHANNELS_MONO   = 16'd1;
  localparam logic [15:0] CHANNELS_STEREO = 16'd2;
  localparam logic [15:0] BITS_PER_SAMPLE = 16'd16;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_RIFF     = 4'd1,
    ERR_WAVE     = 4'd2,
    ERR_FMT_ID   = 4'd3,
    ERR_FMT_SIZE = 4'd4,
    ERR_TAG      = 4'd5,
    ERR_CHANNELS = 4'd6,
    ERR_BITS     = 4'd7,
    ERR_DATA_ID  = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       clear_peak;
  } item_t;

  typedef struct packed {
    kind_t        kind;
    err_t         error_code;
    logic [31:0]  sample_rate;
    logic [1:0]   channel_count;
    logic [30:0]  frame_count;
    logic [15:0]  sample_value;
    logic         channel_index;
    logic [15:0]  peak;
    logic         last;
  } result_t;

endpackage

// ===== hdl/pwsp_in_reg.sv =====
// Input register of the PCM WAV stream parser: holds one accepted item until
// the parser takes it. Depends on pwsp_pkg.
module pwsp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  pwsp_pkg::item_t s_item,
  input  logic           take,
  output logic           item_valid,
  output pwsp_pkg::item_t item
);
  import pwsp_pkg::*;

  // Refill in the same cycle the held item is taken.
  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item <= s_item;
    end
  end

endmodule

// ===== hdl/pwsp_parser.sv =====
// Header parser and sample unpacker of the PCM WAV stream parser: state and
// single-pass next-state logic for one byte item. Depends on pwsp_pkg.
module pwsp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  pwsp_pkg::item_t    item,
  input  logic               out_free,
  output logic               take,
  output logic               res_valid,
  output pwsp_pkg::result_t  res
);
  import pwsp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_SKIP,
    PH_DHDR,
    PH_DATA
  } phase_t;

  localparam logic [5:0] POS_RIFF_ID   = 6'd3;
  localparam logic [5:0] POS_WAVE_ID   = 6'd11;
  localparam logic [5:0] POS_FMT_ID    = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_FMT_TAG   = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_BITS      = 6'd35;
  localparam logic [5:0] POS_DATA_ID   = 6'd3;
  localparam logic [5:0] POS_DATA_SIZE = 6'd7;

  phase_t               phase, phase_next, ph_e;
  logic [5:0]           byte_position, byte_position_next, bp_e;
  logic [31:0]          field_shift, field_shift_next, fs_e, fs_new;
  logic [EXTRA_W-1:0]   extra_fmt_bytes, extra_fmt_bytes_next, ex_e;
  logic [1:0]           channels_seen, channels_seen_next, chs_e;
  logic [31:0]          rate_seen, rate_seen_next, rate_e;
  logic [30:0]          samples_left, samples_left_next, sl_e, sl_dec;
  logic [7:0]           low_byte_hold, low_byte_hold_next, low_e;
  logic                 odd_byte, odd_byte_next, odd_e;
  logic                 channel_toggle, channel_toggle_next, tog_e;
  logic [15:0]          peak_level, peak_level_next, peak_e;
  logic [15:0]          hi16, raw, mag, peak_new;
  logic [30:0]          frames, samples;
  logic                 stereo;

  assign take = item_valid && out_free;

  always_comb begin
    // Start and peak clear act before the byte itself is handled.
    peak_e = item.clear_peak ? 16'd0 : peak_level;
    ph_e   = phase;
    bp_e   = byte_position;
    fs_e   = field_shift;
    ex_e   = extra_fmt_bytes;
    chs_e  = channels_seen;
    rate_e = rate_seen;
    sl_e   = samples_left;
    low_e  = low_byte_hold;
    odd_e  = odd_byte;
    tog_e  = channel_toggle;
    if (item.start_req) begin
      ph_e   = PH_HDR;
      bp_e   = '0;
      fs_e   = '0;
      ex_e   = '0;
      chs_e  = '0;
      rate_e = '0;
      sl_e   = '0;
      low_e  = '0;
      odd_e  = 1'b0;
      tog_e  = 1'b0;
    end

    phase_next           = ph_e;
    byte_position_next   = bp_e;
    field_shift_next     = fs_e;
    extra_fmt_bytes_next = ex_e;
    channels_seen_next   = chs_e;
    rate_seen_next       = rate_e;
    samples_left_next    = sl_e;
    low_byte_hold_next   = low_e;
    odd_byte_next        = odd_e;
    channel_toggle_next  = tog_e;
    peak_level_next      = peak_e;
    res_valid            = 1'b0;
    res                  = '0;

    fs_new   = {item.data_byte, fs_e[31:8]};
    hi16     = fs_new[31:16];
    raw      = {item.data_byte, low_e};
    mag      = raw[15] ? (~raw + 16'd1) : raw;
    peak_new = (mag > peak_e) ? mag : peak_e;
    sl_dec   = sl_e - 31'd1;
    stereo   = (chs_e == 2'd2);
    frames   = stereo ? {1'b0, fs_new[31:2]} : fs_new[31:1];
    samples  = stereo ? {fs_new[31:2], 1'b0} : fs_new[31:1];

    unique case (ph_e)
      PH_IDLE: begin
      end
      PH_DATA: begin
        if (!odd_e) begin
          low_byte_hold_next = item.data_byte;
          odd_byte_next      = 1'b1;
        end else begin
          odd_byte_next       = 1'b0;
          peak_level_next     = peak_new;
          res_valid           = 1'b1;
          res.kind            = KIND_SAMPLE;
          res.sample_value    = raw;
          res.channel_index   = tog_e;
          res.peak            = peak_new;
          res.last            = (sl_e == 31'd1);
          samples_left_next   = sl_dec;
          channel_toggle_next = stereo ? !tog_e : 1'b0;
          if (sl_dec == '0) begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_SKIP: begin
        if (ex_e != '0) begin
          extra_fmt_bytes_next = ex_e - EXTRA_W'(1);
        end
        if (ex_e <= EXTRA_W'(1)) begin
          phase_next         = PH_DHDR;
          byte_position_next = '0;
        end
      end
      PH_HDR: begin
        field_shift_next   = fs_new;
        byte_position_next = bp_e + 6'd1;
        res.kind           = KIND_REJECT;
        case (bp_e)
          POS_RIFF_ID: begin
            if (fs_new != TAG_RIFF) begin
              res_valid      = 1'b1;
              res.error_code = ERR_RIFF;
            end
          end
          POS_WAVE_ID: begin
            if (fs_new != TAG_WAVE) begin
              res_valid      = 1'b1;
              res.error_code = ERR_WAVE;
            end
          end
          POS_FMT_ID: begin
            if (fs_new != TAG_FMT) begin
              res_valid      = 1'b1;
              res.error_code = ERR_FMT_ID;
            end
          end
          POS_FMT_SIZE: begin
            if (fs_new < FMT_SIZE_MIN || fs_new > FMT_SIZE_MAX) begin
              res_valid      = 1'b1;
              res.error_code = ERR_FMT_SIZE;
            end
            extra_fmt_bytes_next = EXTRA_W'(fs_new - FMT_SIZE_MIN);
          end
          POS_FMT_TAG: begin
            if (hi16 != FMT_TAG_PCM) begin
              res_valid      = 1'b1;
              res.error_code = ERR_TAG;
            end
          end
          POS_CHANNELS: begin
            if (hi16 != CHANNELS_MONO && hi16 != CHANNELS_STEREO) begin
              res_valid      = 1'b1;
              res.error_code = ERR_CHANNELS;
            end
            channels_seen_next = hi16[1:0];
          end
          POS_RATE: begin
            rate_seen_next = fs_new;
          end
          POS_BITS: begin
            if (hi16 != BITS_PER_SAMPLE) begin
              res_valid      = 1'b1;
              res.error_code = ERR_BITS;
            end
            byte_position_next = '0;
            phase_next         = (ex_e != '0) ? PH_SKIP : PH_DHDR;
          end
          default: begin
          end
        endcase
        if (res_valid) begin
          phase_next = PH_IDLE;
        end
      end
      PH_DHDR: begin
        field_shift_next   = fs_new;
        byte_position_next = bp_e + 6'd1;
        if (bp_e == POS_DATA_ID && fs_new != TAG_DATA) begin
          res_valid      = 1'b1;
          res.kind       = KIND_REJECT;
          res.error_code = ERR_DATA_ID;
          phase_next     = PH_IDLE;
        end else if (bp_e == POS_DATA_SIZE) begin
          samples_left_next   = samples;
          channel_toggle_next = 1'b0;
          odd_byte_next       = 1'b0;
          res_valid           = 1'b1;
          res.kind            = KIND_ACCEPT;
          res.sample_rate     = rate_e;
          res.channel_count   = stereo ? 2'd2 : 2'd1;
          res.frame_count     = frames;
          res.peak            = peak_e;
          res.last            = (samples == '0);
          phase_next          = (samples != '0) ? PH_DATA : PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_position   <= '0;
      field_shift     <= '0;
      extra_fmt_bytes <= '0;
      channels_seen   <= '0;
      rate_seen       <= '0;
      samples_left    <= '0;
      low_byte_hold   <= '0;
      odd_byte        <= 1'b0;
      channel_toggle  <= 1'b0;
      peak_level      <= '0;
    end else if (take) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      field_shift     <= field_shift_next;
      extra_fmt_bytes <= extra_fmt_bytes_next;
      channels_seen   <= channels_seen_next;
      rate_seen       <= rate_seen_next;
      samples_left    <= samples_left_next;
      low_byte_hold   <= low_byte_hold_next;
      odd_byte        <= odd_byte_next;
      channel_toggle  <= channel_toggle_next;
      peak_level      <= peak_level_next;
    end
  end

endmodule

// ===== hdl/pwsp_out_reg.sv =====
// Result register of the PCM WAV stream parser: holds one result item until
// the downstream side takes it. Depends on pwsp_pkg.
module pwsp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pwsp_pkg::result_t res,
  output logic              out_free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output pwsp_pkg::result_t m_res
);
  import pwsp_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// ===== hdl/pcm_wav_stream_parser_top.sv =====
// Top level of the PCM WAV stream parser: input register, parser, result
// register. Depends on pwsp_pkg, pwsp_in_reg, pwsp_parser, pwsp_out_reg.
//
// Feed a WAV file one byte per item, with start_req set on its first byte.
// The block checks a 16-bit PCM RIFF/WAVE header (mono or stereo, format
// chunk of 16 to 16+MAX_FMT_EXTRA bytes), then emits one accept item (rate,
// channels, frame count) or one reject item (error code) and, after an
// accept, one sample item per two data bytes, with tlast on the final
// sample. An item can be accepted each cycle, a byte is held in the input
// register and its result in the result register on the way out. Throughput
// drops only while the result register is full and m_tready is low.
module pcm_wav_stream_parser_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic [1:0]   s_tuser,   // start_req, clear_peak
  output logic         m_tvalid,
  input  logic         m_tready,
  // error_code, sample_rate, channel_count, frame_count, sample_value,
  // channel_index, peak, zero fill
  output logic [103:0] m_tdata,
  output logic [1:0]   m_tuser,   // kind
  output logic         m_tlast    // last
);
  import pwsp_pkg::*;

  item_t   s_item, item;
  result_t res, m_res;
  logic    item_valid, take, res_valid, out_free;

  assign s_item.data_byte  = s_tdata;
  assign s_item.start_req  = s_tuser[0];
  assign s_item.clear_peak = s_tuser[1];

  pwsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pwsp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  pwsp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {2'b00, m_res.peak, m_res.channel_index, m_res.sample_value,
                    m_res.frame_count, m_res.channel_count, m_res.sample_rate,
                    m_res.error_code};
  assign m_tuser = m_res.kind;
  assign m_tlast = m_res.last;

endmodule
